@@ rtl/core/snp_prp_pkg.sv @@
// ----------------------------------------------------------------------------
// snp_prp_pkg
// shared constants and types of the snp packet receive parser
// ----------------------------------------------------------------------------
package snp_prp_pkg;

   localparam int MAX_WORDS_DEF = 15;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int SUM_W   = 16;
   localparam int WIDX_W  = 4;
   localparam int BCNT_W  = 6;
   localparam int CSR_IDX_W = 4;

   localparam logic [BYTE_W-1:0] CH_S = 8'h73;
   localparam logic [BYTE_W-1:0] CH_N = 8'h6E;
   localparam logic [BYTE_W-1:0] CH_P = 8'h70;
   localparam logic [SUM_W-1:0]  HDR_SUM = 16'(CH_S) + 16'(CH_N) + 16'(CH_P);

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ADDRESS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_PER_BUFFER = 4'd1;

   // payload word write into the store
   typedef struct packed {
      logic              en;
      logic [WIDX_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } store_wr_type;

   // packet finished, start of result emission
   typedef struct packed {
      logic              load;
      logic              status;
      logic              carries_data;
      logic [WIDX_W-1:0] count;
      logic [BYTE_W-1:0] type_code;
      logic [BYTE_W-1:0] reg_address;
      logic [SUM_W-1:0]  checksum;
   } emit_cmd_type;

endpackage

@@ rtl/core/snp_prp_req_if.sv @@
// ----------------------------------------------------------------------------
// snp_prp_req_if
// received byte channel
// ----------------------------------------------------------------------------
interface snp_prp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       buffer_end;

   modport source (output valid, output rx_byte, output buffer_end, input ready);
   modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

@@ rtl/core/snp_prp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// snp_prp_rsp_if
// result channel, one word per register of a packet
// ----------------------------------------------------------------------------
interface snp_prp_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [7:0]  type_code;
   logic [7:0]  reg_address;
   logic        carries_data;
   logic [3:0]  word_index;
   logic [31:0] data_word;
   logic [15:0] checksum;
   logic        last;

   modport source (output valid, output status, output type_code, output reg_address,
                   output carries_data, output word_index, output data_word,
                   output checksum, output last, input ready);
   modport sink   (input valid, input status, input type_code, input reg_address,
                   input carries_data, input word_index, input data_word,
                   input checksum, input last, output ready);
endinterface

@@ rtl/core/snp_prp_csr_if.sv @@
// ----------------------------------------------------------------------------
// snp_prp_csr_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface snp_prp_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/snp_prp_parser.sv @@
// ----------------------------------------------------------------------------
// snp_prp_parser
// header hunt, type and address check, checksum, payload word assembly
// ----------------------------------------------------------------------------
module snp_prp_parser #(
   parameter int MAX_WORDS = snp_prp_pkg::MAX_WORDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  rx_byte,
   input  logic                        buffer_end,
   input  logic [7:0]                  target_address,
   input  logic                        one_per_buffer,
   output snp_prp_pkg::store_wr_type   store_wr,
   output snp_prp_pkg::emit_cmd_type   emit_cmd
);

   typedef enum logic [3:0] {
      PH_HUNT, PH_GOT_S, PH_GOT_N, PH_TYPE, PH_ADDR, PH_PAYLOAD, PH_CK_HI, PH_CK_LO
   } phase_type;

   localparam logic [snp_prp_pkg::WIDX_W-1:0] MAX_W = snp_prp_pkg::WIDX_W'(MAX_WORDS);

   function automatic phase_type hunt_feed(input phase_type ph, input logic [7:0] b);
      phase_type r;
      r = PH_HUNT;
      if (b == snp_prp_pkg::CH_S) begin
         r = PH_GOT_S;
      end else if (ph == PH_GOT_S && b == snp_prp_pkg::CH_N) begin
         r = PH_GOT_N;
      end else if (ph == PH_GOT_N && b == snp_prp_pkg::CH_P) begin
         r = PH_TYPE;
      end
      return r;
   endfunction

   phase_type                          phase_ff, phase_in;
   logic                               skip_ff, skip_in;
   logic [7:0]                         type_ff, type_in;
   logic [7:0]                         addr_ff, addr_in;
   logic [snp_prp_pkg::BCNT_W-1:0]     len_ff, len_in;
   logic [snp_prp_pkg::WIDX_W-1:0]     words_ff, words_in;
   logic [snp_prp_pkg::BCNT_W-1:0]     cnt_ff, cnt_in;
   logic [15:0]                        sum_ff, sum_in;
   logic [7:0]                         ckhi_ff, ckhi_in;
   logic [23:0]                        asm_ff, asm_in;

   logic [snp_prp_pkg::WIDX_W-1:0]     words_calc;
   logic [snp_prp_pkg::BCNT_W-1:0]     cnt_inc;
   logic                               bad_sum;

   always_comb begin
      phase_in = phase_ff;
      skip_in  = skip_ff;
      type_in  = type_ff;
      addr_in  = addr_ff;
      len_in   = len_ff;
      words_in = words_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      ckhi_in  = ckhi_ff;
      asm_in   = asm_ff;
      store_wr = '0;
      emit_cmd = '0;
      emit_cmd.type_code   = type_ff;
      emit_cmd.reg_address = addr_ff;
      emit_cmd.checksum    = sum_ff;

      words_calc = '0;
      if (rx_byte[7]) begin
         words_calc = rx_byte[6] ? rx_byte[5:2] : snp_prp_pkg::WIDX_W'(1);
      end
      cnt_inc = cnt_ff + snp_prp_pkg::BCNT_W'(1);
      bad_sum = ({ckhi_ff, rx_byte} != sum_ff);

      if (accept) begin
         if (!skip_ff) begin
            unique case (phase_ff)
               PH_TYPE: begin
                  type_in = rx_byte;
                  if (words_calc > MAX_W) begin
                     phase_in = hunt_feed(PH_HUNT, rx_byte);
                  end else begin
                     words_in = words_calc;
                     len_in   = {words_calc, 2'b00};
                     cnt_in   = '0;
                     sum_in   = snp_prp_pkg::HDR_SUM + 16'(rx_byte);
                     phase_in = PH_ADDR;
                  end
               end
               PH_ADDR: begin
                  addr_in = rx_byte;
                  if (rx_byte != target_address) begin
                     phase_in = hunt_feed(hunt_feed(PH_HUNT, type_ff), rx_byte);
                  end else begin
                     sum_in   = sum_ff + 16'(rx_byte);
                     phase_in = (len_ff == '0) ? PH_CK_HI : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  sum_in = sum_ff + 16'(rx_byte);
                  cnt_in = cnt_inc;
                  asm_in = {asm_ff[15:0], rx_byte};
                  if (cnt_ff[1:0] == 2'd3) begin
                     store_wr.en   = 1'b1;
                     store_wr.addr = cnt_ff[5:2];
                     store_wr.data = {asm_ff, rx_byte};
                  end
                  if (cnt_inc >= len_ff) begin
                     phase_in = PH_CK_HI;
                  end
               end
               PH_CK_HI: begin
                  ckhi_in  = rx_byte;
                  phase_in = PH_CK_LO;
               end
               PH_CK_LO: begin
                  emit_cmd.load         = 1'b1;
                  emit_cmd.status       = bad_sum;
                  emit_cmd.carries_data = !bad_sum && (words_ff != '0);
                  emit_cmd.count        = emit_cmd.carries_data ? words_ff
                                                                : snp_prp_pkg::WIDX_W'(1);
                  phase_in = PH_HUNT;
                  if (one_per_buffer) begin
                     skip_in = 1'b1;
                  end
               end
               default: begin
                  phase_in = hunt_feed(phase_ff, rx_byte);
               end
            endcase
         end
         if (buffer_end) begin
            phase_in = PH_HUNT;
            skip_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         skip_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
      end
      type_ff  <= type_in;
      addr_ff  <= addr_in;
      len_ff   <= len_in;
      words_ff <= words_in;
      cnt_ff   <= cnt_in;
      sum_ff   <= sum_in;
      ckhi_ff  <= ckhi_in;
      asm_ff   <= asm_in;
   end

endmodule

@@ rtl/core/snp_prp_emitter.sv @@
// ----------------------------------------------------------------------------
// snp_prp_emitter
// payload word store, read sequencer and result output register
// ----------------------------------------------------------------------------
module snp_prp_emitter #(
   parameter int MAX_WORDS = snp_prp_pkg::MAX_WORDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  snp_prp_pkg::store_wr_type   store_wr,
   input  snp_prp_pkg::emit_cmd_type   emit_cmd,
   output logic                        idle,
   snp_prp_rsp_if.source               rsp_bus
);

   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int IW = snp_prp_pkg::WIDX_W;

   logic [31:0] mem [0:MAX_WORDS-1];

   // sequencer
   logic [IW-1:0] left_ff, left_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          status_ff, carries_ff;
   logic [7:0]    ptype_ff, addr_ff;
   logic [15:0]   sum_ff;

   // read stage
   logic          s1_valid_ff, s1_valid_in;
   logic [31:0]   rd_data_ff;
   logic [IW-1:0] s1_idx_ff;
   logic          s1_last_ff, s1_status_ff, s1_carries_ff;
   logic [7:0]    s1_ptype_ff, s1_addr_ff;
   logic [15:0]   s1_sum_ff;

   // output stage
   logic          out_valid_ff, out_valid_in;
   logic          out_status_ff, out_carries_ff, out_last_ff;
   logic [7:0]    out_ptype_ff, out_addr_ff;
   logic [IW-1:0] out_idx_ff;
   logic [31:0]   out_data_ff;
   logic [15:0]   out_sum_ff;

   logic move;
   logic issue;

   assign idle  = (left_ff == '0);
   assign move  = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign issue = !idle && (!s1_valid_ff || move);

   always_comb begin
      left_in = left_ff;
      idx_in  = idx_ff;
      if (emit_cmd.load) begin
         left_in = emit_cmd.count;
         idx_in  = '0;
      end else if (issue) begin
         left_in = left_ff - IW'(1);
         idx_in  = idx_ff + IW'(1);
      end
      s1_valid_in  = issue ? 1'b1 : (move ? 1'b0 : s1_valid_ff);
      out_valid_in = move ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         mem[store_wr.addr[AW-1:0]] <= store_wr.data;
      end
      if (issue) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff <= idx_in;
      if (emit_cmd.load) begin
         status_ff  <= emit_cmd.status;
         carries_ff <= emit_cmd.carries_data;
         ptype_ff   <= emit_cmd.type_code;
         addr_ff    <= emit_cmd.reg_address;
         sum_ff     <= emit_cmd.checksum;
      end
      if (issue) begin
         s1_idx_ff     <= idx_ff;
         s1_last_ff    <= (left_ff == IW'(1));
         s1_status_ff  <= status_ff;
         s1_carries_ff <= carries_ff;
         s1_ptype_ff   <= ptype_ff;
         s1_addr_ff    <= addr_ff;
         s1_sum_ff     <= sum_ff;
      end
      if (move) begin
         out_status_ff  <= s1_status_ff;
         out_carries_ff <= s1_carries_ff;
         out_last_ff    <= s1_last_ff;
         out_ptype_ff   <= s1_ptype_ff;
         out_addr_ff    <= s1_addr_ff;
         out_idx_ff     <= s1_idx_ff;
         out_data_ff    <= s1_carries_ff ? rd_data_ff : '0;
         out_sum_ff     <= s1_sum_ff;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.type_code    = out_ptype_ff;
   assign rsp_bus.reg_address  = out_addr_ff;
   assign rsp_bus.carries_data = out_carries_ff;
   assign rsp_bus.word_index   = out_idx_ff;
   assign rsp_bus.data_word    = out_data_ff;
   assign rsp_bus.checksum     = out_sum_ff;
   assign rsp_bus.last         = out_last_ff;

endmodule

@@ rtl/core/snp_packet_receive_parser.sv @@
// ----------------------------------------------------------------------------
// snp_packet_receive_parser
// framed register packet receiver: header hunt, checksum check, word output
// ----------------------------------------------------------------------------
//  channel   dir  word                                     accepted when
//  req_bus   in   rx_byte, buffer_end                      valid && ready
//  rsp_bus   out  status, type, address, index, data, sum  valid && ready
//  csr_bus   in   index, data                              valid (ready tied high)
//
//  one received byte per cycle while idle; after the byte that carries the low
//  checksum byte no input is taken until all result words (1 to MAX_WORDS) have
//  left the single read port of the payload word store, longer while rsp_bus
//  stalls. results leave through a read stage and an output register.
//  reset is synchronous; the payload store has no reset and needs no clearing.
// ----------------------------------------------------------------------------
module snp_packet_receive_parser #(
   parameter int MAX_WORDS = snp_prp_pkg::MAX_WORDS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   snp_prp_req_if.sink   req_bus,
   snp_prp_rsp_if.source rsp_bus,
   snp_prp_csr_if.sink   csr_bus
);

   logic [7:0] target_ff;
   logic       opb_ff;
   logic       idle;
   logic       accept;

   snp_prp_pkg::store_wr_type store_wr;
   snp_prp_pkg::emit_cmd_type emit_cmd;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = idle;
   assign accept        = req_bus.valid && idle;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         opb_ff    <= 1'b1;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            snp_prp_pkg::CSR_TARGET_ADDRESS: target_ff <= csr_bus.data;
            snp_prp_pkg::CSR_ONE_PER_BUFFER: opb_ff    <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   snp_prp_parser #(
      .MAX_WORDS (MAX_WORDS)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .rx_byte        (req_bus.rx_byte),
      .buffer_end     (req_bus.buffer_end),
      .target_address (target_ff),
      .one_per_buffer (opb_ff),
      .store_wr       (store_wr),
      .emit_cmd       (emit_cmd)
   );

   snp_prp_emitter #(
      .MAX_WORDS (MAX_WORDS)
   ) u_emitter (
      .clock    (clock),
      .reset    (reset),
      .store_wr (store_wr),
      .emit_cmd (emit_cmd),
      .idle     (idle),
      .rsp_bus  (rsp_bus)
   );

endmodule

@@ tb/snp_packet_receive_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_packet_receive_parser_tb
// self-checking bench for the snp packet receive parser: directed header,
// address and checksum cases, then random packet traffic with noise, cut
// packets and buffer ends under several register settings, checked word by
// word against a cycle-free parser model, with random stalls on both sides
// ----------------------------------------------------------------------------
module snp_packet_receive_parser_tb;

   typedef enum logic [3:0] {
      HUNT_S, SEEN_S, SEEN_N, TAKE_TYPE, TAKE_ADDR, TAKE_PAYLOAD, TAKE_CK_HI, TAKE_CK_LO
   } parse_phase_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  type_code;
      logic [7:0]  reg_address;
      logic        carries_data;
      logic [3:0]  word_index;
      logic [31:0] data_word;
      logic [15:0] checksum;
      logic        last;
   } reg_word_type;

   localparam int STORE_BYTES = 4 * snp_prp_pkg::MAX_WORDS_DEF;

   logic clock;
   logic reset;

   snp_prp_req_if req_bus();
   snp_prp_rsp_if rsp_bus();
   snp_prp_csr_if csr_bus();

   snp_packet_receive_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // parser model state
   parse_phase_type ph    = HUNT_S;
   logic [7:0]   pk_type  = '0;
   logic [7:0]   pk_addr  = '0;
   int           pay_len  = 0;
   int           byte_cnt = 0;
   logic [15:0]  run_sum  = '0;
   logic [7:0]   ck_hi    = '0;
   logic [7:0]   pay_store [STORE_BYTES];
   bit           skip_rest = 1'b0;

   logic [7:0]   cfg_target = 8'h00;
   bit           cfg_one_per_buffer = 1'b1;

   reg_word_type expected_words [$];
   reg_word_type want;

   int  errors       = 0;
   int  bytes_sent   = 0;
   int  words_seen   = 0;
   int  good_packets = 0;
   int  bad_packets  = 0;
   bit  idle_on      = 1'b1;
   int  stall_left   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic parse_phase_type header_step(parse_phase_type cur, logic [7:0] b);
      if (b == snp_prp_pkg::CH_S) return SEEN_S;
      if (cur == SEEN_S && b == snp_prp_pkg::CH_N) return SEEN_N;
      if (cur == SEEN_N && b == snp_prp_pkg::CH_P) return TAKE_TYPE;
      return HUNT_S;
   endfunction

   function void push_word(logic st, logic hd, logic [3:0] idx, logic [31:0] dw, logic lst);
      reg_word_type w;
      w.status       = st;
      w.type_code    = pk_type;
      w.reg_address  = pk_addr;
      w.carries_data = hd;
      w.word_index   = idx;
      w.data_word    = dw;
      w.checksum     = run_sum;
      w.last         = lst;
      expected_words.push_back(w);
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic be);
      int len;
      int words;
      if (!skip_rest) begin
         case (ph)
            TAKE_TYPE: begin
               len = b[7] ? (b[6] ? 4 * int'(b[5:2]) : 4) : 0;
               pk_type = b;
               if (len > STORE_BYTES) begin
                  ph = header_step(HUNT_S, b);
               end else begin
                  pay_len  = len;
                  byte_cnt = 0;
                  run_sum  = snp_prp_pkg::HDR_SUM + 16'(b);
                  ph       = TAKE_ADDR;
               end
            end
            TAKE_ADDR: begin
               pk_addr = b;
               if (b != cfg_target) begin
                  ph = header_step(header_step(HUNT_S, pk_type), b);
               end else begin
                  run_sum = run_sum + 16'(b);
                  ph = (pay_len == 0) ? TAKE_CK_HI : TAKE_PAYLOAD;
               end
            end
            TAKE_PAYLOAD: begin
               if (byte_cnt < STORE_BYTES) pay_store[byte_cnt] = b;
               run_sum  = run_sum + 16'(b);
               byte_cnt = byte_cnt + 1;
               if (byte_cnt >= pay_len) ph = TAKE_CK_HI;
            end
            TAKE_CK_HI: begin
               ck_hi = b;
               ph    = TAKE_CK_LO;
            end
            TAKE_CK_LO: begin
               words = pay_len / 4;
               if ({ck_hi, b} != run_sum) begin
                  push_word(1'b1, 1'b0, 4'd0, 32'd0, 1'b1);
                  bad_packets++;
               end else if (words == 0) begin
                  push_word(1'b0, 1'b0, 4'd0, 32'd0, 1'b1);
                  good_packets++;
               end else begin
                  for (int k = 0; k < words && k < snp_prp_pkg::MAX_WORDS_DEF; k++) begin
                     push_word(1'b0, 1'b1, 4'(k),
                               {pay_store[4*k], pay_store[4*k+1],
                                pay_store[4*k+2], pay_store[4*k+3]},
                               k + 1 == words);
                  end
                  good_packets++;
               end
               ph = HUNT_S;
               if (cfg_one_per_buffer) skip_rest = 1'b1;
            end
            default: begin
               ph = header_step(ph, b);
            end
         endcase
      end
      if (be) begin
         ph        = HUNT_S;
         skip_rest = 1'b0;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic be);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 12);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.rx_byte    = b;
      req_bus.buffer_end = be;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      parse_byte(b, be);
      bytes_sent++;
   endtask

   task automatic send_packet(input logic [7:0] typ, input logic [7:0] addr,
                              input bit bad_sum, input bit end_after, input int cut);
      logic [7:0]  pkt [$];
      logic [15:0] sum;
      int          len;
      len = typ[7] ? (typ[6] ? 4 * int'(typ[5:2]) : 4) : 0;
      pkt = {snp_prp_pkg::CH_S, snp_prp_pkg::CH_N, snp_prp_pkg::CH_P, typ, addr};
      repeat (len) pkt.push_back(8'($urandom));
      sum = '0;
      foreach (pkt[i]) sum = sum + 16'(pkt[i]);
      if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(0, 15));
      pkt.push_back(sum[15:8]);
      pkt.push_back(sum[7:0]);
      if (cut > 0 && cut < pkt.size()) pkt = pkt[0:cut-1];
      foreach (pkt[i]) send_byte(pkt[i], (end_after || cut > 0) && i == pkt.size() - 1);
   endtask

   task automatic write_reg(input logic [snp_prp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] val);
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = val;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      case (idx)
         snp_prp_pkg::CSR_TARGET_ADDRESS: cfg_target = val;
         snp_prp_pkg::CSR_ONE_PER_BUFFER: cfg_one_per_buffer = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_config(input logic [7:0] target, input bit one_per_buffer);
      write_reg(snp_prp_pkg::CSR_TARGET_ADDRESS, target);
      write_reg(snp_prp_pkg::CSR_ONE_PER_BUFFER, {7'd0, one_per_buffer});
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0: return snp_prp_pkg::CH_S;
         1: return snp_prp_pkg::CH_N;
         2: return snp_prp_pkg::CH_P;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] random_type();
      int cnt;
      case ($urandom_range(0, 9))
         0, 1: return {1'b0, 7'($urandom)};
         2, 3, 4: return {2'b10, 6'($urandom)};
         default: begin
            cnt = ($urandom_range(0, 11) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
            return {2'b11, 4'(cnt), 2'($urandom)};
         end
      endcase
   endfunction

   task automatic test_header_hunt();
      // repeated s ahead of the header, empty packet
      send_byte(snp_prp_pkg::CH_S, 1'b0);
      send_packet(8'h00, 8'h00, 1'b0, 1'b1, 0);
   endtask

   task automatic test_address_filter();
      // wrong address, buffer end right after it
      send_packet(8'h80, 8'hA5, 1'b0, 1'b0, 5);
   endtask

   task automatic test_checksum_error();
      // bad sum, then bytes skipped until buffer end
      send_packet(8'h80, 8'h00, 1'b1, 1'b0, 0);
      send_byte(snp_prp_pkg::CH_S, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_full_batch();
      set_config(8'hFF, 1'b0);
      send_packet(8'hFF, 8'hFF, 1'b0, 1'b0, 0);
      send_packet(8'hC0, 8'hFF, 1'b0, 1'b0, 0);
   endtask

   task automatic test_random_traffic(input int n_bytes);
      int         stop_at;
      int         kind;
      logic [7:0] addr;
      bit         ended;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(0, 19);
         addr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg_target;
         if (kind < 2) begin
            repeat ($urandom_range(1, 4)) send_byte(noise_byte(), $urandom_range(0, 7) == 0);
         end else if (kind < 4) begin
            send_packet(random_type(), addr, 1'b0, 1'b1, $urandom_range(1, 7));
         end else begin
            ended = $urandom_range(0, 1);
            send_packet(random_type(), addr, $urandom_range(0, 6) == 0, ended, 0);
            if (!ended && cfg_one_per_buffer) begin
               repeat ($urandom_range(0, 2)) send_byte(noise_byte(), 1'b0);
               send_byte(noise_byte(), 1'b1);
            end
         end
      end
   endtask

   // result side stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left    <= $urandom_range(0, 11);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   function void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_seen++;
         if (expected_words.size() == 0) begin
            $display("%0t: word with nothing expected, expected none actual type %0h idx %0h",
                     $time, rsp_bus.type_code, rsp_bus.word_index);
            errors++;
         end else begin
            want = expected_words.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            check_field("type_code", 32'(want.type_code), 32'(rsp_bus.type_code));
            check_field("reg_address", 32'(want.reg_address), 32'(rsp_bus.reg_address));
            check_field("carries_data", 32'(want.carries_data), 32'(rsp_bus.carries_data));
            check_field("word_index", 32'(want.word_index), 32'(rsp_bus.word_index));
            check_field("data_word", want.data_word, rsp_bus.data_word);
            check_field("checksum", 32'(want.checksum), 32'(rsp_bus.checksum));
            check_field("last", 32'(want.last), 32'(rsp_bus.last));
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.rx_byte    = '0;
      req_bus.buffer_end = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_config(8'h00, 1'b1);
      test_header_hunt();
      test_address_filter();
      test_checksum_error();
      test_full_batch();
      test_random_traffic(70);
      set_config(8'h00, 1'b1);
      test_random_traffic(70);
      set_config(snp_prp_pkg::CH_S, 1'b0);
      test_random_traffic(70);
      set_config(8'($urandom), 1'b1);
      idle_on = 1'b0;
      test_random_traffic(80);

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d bytes, %0d good and %0d bad packets, %0d result words",
               bytes_sent, good_packets, bad_packets, words_seen);
      $display("targets 00, ff, 73 and random; one-per-buffer on and off; stalls then none");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
